// File: rtl/aigs_pkg.sv
// Shared types, codes and a helper function of the and-inverter graph simulator.
package aigs_pkg;

    localparam int WORD_W      = 64;
    localparam int SLOT_IN_W   = 12;
    localparam int SLICE_IN_W  = 2;
    localparam int CO_W        = 12;
    localparam int PAT_W       = 8;
    localparam int BIT_W       = 6;
    localparam int CFG_W       = 12;
    localparam int RECIP_SHIFT = 24;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_AND  = 2'd0,
        OP_LOAD = 2'd1,
        OP_OUT  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_CHECK_MITER = 1'b0,
        CFG_NUM_PO      = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_op        op;
        logic       wr_en;
        logic       src0_zero;
        logic       src1_zero;
        logic       inv0;
        logic       inv1;
        logic       fail_en;
        logic [1:0] fail_base;
    } t_ctl;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] n;
        n = BIT_W'(WORD_W - 1);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                n = BIT_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/aigs_queue.sv
// Register queue between the decode front and the execute back.
module aigs_queue
    import aigs_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);

endmodule

// File: rtl/aigs_front.sv
// Decode front: configuration registers, slot and slice wrapping, item classification.
module aigs_front
    import aigs_pkg::*;
#(
    parameter int FRONT_SLOTS = 4096,
    parameter int WORD_SLICES = 4,
    parameter int ADDR_W      = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [SLOT_IN_W-1:0]  i_dest_slot,
    input  logic [SLOT_IN_W-1:0]  i_src0_slot,
    input  logic [SLOT_IN_W-1:0]  i_src1_slot,
    input  logic                  i_invert0,
    input  logic                  i_invert1,
    input  logic [WORD_W-1:0]     i_ci_value,
    input  logic [CO_W-1:0]       i_co_number,
    input  logic [SLICE_IN_W-1:0] i_word_slice,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_ctl                  o_ctl,
    output logic [ADDR_W-1:0]     o_dest_addr,
    output logic [ADDR_W-1:0]     o_src0_addr,
    output logic [ADDR_W-1:0]     o_src1_addr,
    output logic [WORD_W-1:0]     o_ci_value,
    output logic [CO_W-1:0]       o_co_number
);

    localparam int SLOT_W  = $clog2(FRONT_SLOTS);
    localparam int SLICE_W = ADDR_W - SLOT_W;
    localparam int RECIP_I = (1 << RECIP_SHIFT) / FRONT_SLOTS;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'(RECIP_I);
    localparam int PROD_W  = SLOT_IN_W + RECIP_SHIFT;
    localparam int FOLD_W  = SLOT_W + 1;
    localparam int MUL_W   = SLOT_IN_W + FOLD_W;

    function automatic logic [SLOT_IN_W-1:0] slot_quot(input logic [SLOT_IN_W-1:0] v);
        logic [PROD_W-1:0] p;
        p = PROD_W'(v) * PROD_W'(RECIP);
        return p[PROD_W-1:RECIP_SHIFT];
    endfunction

    function automatic logic [SLOT_IN_W-1:0] slot_rem(input logic [SLOT_IN_W-1:0] v,
                                                      input logic [SLOT_IN_W-1:0] q);
        logic [MUL_W-1:0] p;
        p = MUL_W'(q) * MUL_W'(FRONT_SLOTS);
        return v - p[SLOT_IN_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_fold(input logic [SLOT_IN_W-1:0] r);
        logic [FOLD_W+SLOT_IN_W-1:0] w;
        w = (FOLD_W + SLOT_IN_W)'(r);
        if (w >= (FOLD_W + SLOT_IN_W)'(FRONT_SLOTS)) begin
            w = w - (FOLD_W + SLOT_IN_W)'(FRONT_SLOTS);
        end
        return SLOT_W'(w);
    endfunction

    logic                  r_check_miter;
    logic [CFG_W-1:0]      r_num_po;

    logic                  r_s1_valid;
    t_op                   r_s1_op;
    logic [SLOT_IN_W-1:0]  r_s1_vd;
    logic [SLOT_IN_W-1:0]  r_s1_v0;
    logic [SLOT_IN_W-1:0]  r_s1_v1;
    logic [SLOT_IN_W-1:0]  r_s1_qd;
    logic [SLOT_IN_W-1:0]  r_s1_q0;
    logic [SLOT_IN_W-1:0]  r_s1_q1;
    logic [SLICE_W-1:0]    r_s1_slice;
    logic [1:0]            r_s1_base;
    logic                  r_s1_inv0;
    logic                  r_s1_inv1;
    logic [WORD_W-1:0]     r_s1_civ;
    logic [CO_W-1:0]       r_s1_co;
    logic                  r_s1_fail_en;

    logic                  r_s2_valid;
    t_op                   r_s2_op;
    logic [SLOT_IN_W-1:0]  r_s2_rd;
    logic [SLOT_IN_W-1:0]  r_s2_r0;
    logic [SLOT_IN_W-1:0]  r_s2_r1;
    logic [SLICE_W-1:0]    r_s2_slice;
    logic [1:0]            r_s2_base;
    logic                  r_s2_inv0;
    logic                  r_s2_inv1;
    logic [WORD_W-1:0]     r_s2_civ;
    logic [CO_W-1:0]       r_s2_co;
    logic                  r_s2_fail_en;

    logic                  en;
    logic [7:0]            n_slice;
    logic [SLOT_W-1:0]     dslot;
    logic [SLOT_W-1:0]     s0slot;
    logic [SLOT_W-1:0]     s1slot;

    assign en         = !r_s2_valid || !i_q_full;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_miter <= 1'b0;
            r_num_po      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CHECK_MITER: r_check_miter <= i_cfg_data[0];
                CFG_NUM_PO:      r_num_po      <= i_cfg_data;
                default:         r_num_po      <= r_num_po;
            endcase
        end
    end

    always_comb begin
        n_slice = 8'(i_word_slice);
        if (WORD_SLICES == 1) begin
            n_slice = '0;
        end else if (n_slice >= 8'(WORD_SLICES)) begin
            n_slice = n_slice - 8'(WORD_SLICES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid && (t_op'(i_operation) != OP_NONE);
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op      <= t_op'(i_operation);
            r_s1_vd      <= i_dest_slot;
            r_s1_v0      <= i_src0_slot;
            r_s1_v1      <= i_src1_slot;
            r_s1_qd      <= slot_quot(i_dest_slot);
            r_s1_q0      <= slot_quot(i_src0_slot);
            r_s1_q1      <= slot_quot(i_src1_slot);
            r_s1_slice   <= SLICE_W'(n_slice);
            r_s1_base    <= n_slice[1:0];
            r_s1_inv0    <= i_invert0;
            r_s1_inv1    <= i_invert1;
            r_s1_civ     <= i_ci_value;
            r_s1_co      <= i_co_number;
            r_s1_fail_en <= r_check_miter && (i_co_number < r_num_po);

            r_s2_op      <= r_s1_op;
            r_s2_rd      <= slot_rem(r_s1_vd, r_s1_qd);
            r_s2_r0      <= slot_rem(r_s1_v0, r_s1_q0);
            r_s2_r1      <= slot_rem(r_s1_v1, r_s1_q1);
            r_s2_slice   <= r_s1_slice;
            r_s2_base    <= r_s1_base;
            r_s2_inv0    <= r_s1_inv0;
            r_s2_inv1    <= r_s1_inv1;
            r_s2_civ     <= r_s1_civ;
            r_s2_co      <= r_s1_co;
            r_s2_fail_en <= r_s1_fail_en;
        end
    end

    always_comb begin
        dslot  = slot_fold(r_s2_rd);
        s0slot = slot_fold(r_s2_r0);
        s1slot = slot_fold(r_s2_r1);

        o_push            = r_s2_valid && !i_q_full;
        o_ctl.op          = r_s2_op;
        o_ctl.wr_en       = ((r_s2_op == OP_AND) || (r_s2_op == OP_LOAD)) && (dslot != '0);
        o_ctl.src0_zero   = (s0slot == '0);
        o_ctl.src1_zero   = (s1slot == '0);
        o_ctl.inv0        = r_s2_inv0;
        o_ctl.inv1        = r_s2_inv1;
        o_ctl.fail_en     = r_s2_fail_en;
        o_ctl.fail_base   = r_s2_base;
        o_dest_addr       = {r_s2_slice, dslot};
        o_src0_addr       = {r_s2_slice, s0slot};
        o_src1_addr       = {r_s2_slice, s1slot};
        o_ci_value        = r_s2_civ;
        o_co_number       = r_s2_co;
    end

endmodule

// File: rtl/aigs_back.sv
// Execute back: frontier memory, forwarding, AND evaluation and output register.
module aigs_back
    import aigs_pkg::*;
#(
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_pop,
    input  t_ctl              i_ctl,
    input  logic [ADDR_W-1:0] i_dest_addr,
    input  logic [ADDR_W-1:0] i_src0_addr,
    input  logic [ADDR_W-1:0] i_src1_addr,
    input  logic [WORD_W-1:0] i_ci_value,
    input  logic [CO_W-1:0]   i_co_number,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CO_W-1:0]   o_out_index,
    output logic [WORD_W-1:0] o_out_value,
    output logic              o_miter_fail,
    output logic [PAT_W-1:0]  o_fail_pattern
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WORD_W-1:0] mem [DEPTH];

    logic              r_e_valid;
    t_ctl              r_e_ctl;
    logic [ADDR_W-1:0] r_e_dest;
    logic [ADDR_W-1:0] r_e_src0;
    logic [ADDR_W-1:0] r_e_src1;
    logic [WORD_W-1:0] r_e_civ;
    logic [CO_W-1:0]   r_e_co;
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;

    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [WORD_W-1:0] r_wb_data;

    logic              r_o_valid;
    logic [CO_W-1:0]   r_o_index;
    logic [WORD_W-1:0] r_o_value;
    logic              r_o_fail;
    logic [PAT_W-1:0]  r_o_pattern;

    logic              adv;
    logic              e_fire;
    logic              wr;
    logic              out_fire;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] wdata;
    logic              fail;
    logic [PAT_W-1:0]  pattern;

    always_comb begin
        a = r_e_ctl.src0_zero ? '0 :
            (r_wb_valid && (r_wb_addr == r_e_src0)) ? r_wb_data : r_rd0;
        b = r_e_ctl.src1_zero ? '0 :
            (r_wb_valid && (r_wb_addr == r_e_src1)) ? r_wb_data : r_rd1;
        a = a ^ {WORD_W{r_e_ctl.inv0}};
        b = b ^ {WORD_W{r_e_ctl.inv1}};

        adv      = !(r_e_valid && (r_e_ctl.op == OP_OUT) && r_o_valid && !i_out_ready);
        o_pop    = adv && i_q_valid;
        e_fire   = r_e_valid && adv;
        wr       = e_fire && r_e_ctl.wr_en;
        out_fire = e_fire && (r_e_ctl.op == OP_OUT);
        wdata    = (r_e_ctl.op == OP_LOAD) ? r_e_civ : (a & b);
        fail     = r_e_ctl.fail_en && (a != '0);
        pattern  = fail ? {r_e_ctl.fail_base, lowest_set(a)} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[r_e_dest] <= wdata;
        end
        if (o_pop) begin
            r_rd0 <= mem[i_src0_addr];
            r_rd1 <= mem[i_src1_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid  <= 1'b0;
            r_wb_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_e_valid <= i_q_valid;
            end
            if (wr) begin
                r_wb_valid <= 1'b1;
            end
            if (out_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_e_ctl  <= i_ctl;
            r_e_dest <= i_dest_addr;
            r_e_src0 <= i_src0_addr;
            r_e_src1 <= i_src1_addr;
            r_e_civ  <= i_ci_value;
            r_e_co   <= i_co_number;
        end
        if (wr) begin
            r_wb_addr <= r_e_dest;
            r_wb_data <= wdata;
        end
        if (out_fire) begin
            r_o_index   <= r_e_co;
            r_o_value   <= a;
            r_o_fail    <= fail;
            r_o_pattern <= pattern;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_index    = r_o_index;
    assign o_out_value    = r_o_value;
    assign o_miter_fail   = r_o_fail;
    assign o_fail_pattern = r_o_pattern;

endmodule

// File: rtl/aig_bit_parallel_simulator.sv
// Top level of the bit-parallel and-inverter graph simulator.
//
//  channel   direction  handshake                 payload
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//  in        in         i_in_valid / o_in_ready   operation, slots, inverts, ci, co, slice
//  out       out        o_out_valid / i_out_ready out_index, out_value, miter_fail, pattern
//
// One instruction per cycle is taken while o_in_ready is high; dependent AND nodes follow back to back
// through a forwarding register on the single frontier write port.
// From input to output word an instruction passes two decode stages, the queue,
// the memory read with execute, and the output register.
// Reset is synchronous and clears control state only; the frontier is not cleared.
// A stalled output holds execute and fills the four-entry queue before o_in_ready drops.
module aig_bit_parallel_simulator
    import aigs_pkg::*;
#(
    parameter int FRONT_SLOTS = 4096,
    parameter int WORD_SLICES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_operation,
    input  logic [SLOT_IN_W-1:0]  i_dest_slot,
    input  logic [SLOT_IN_W-1:0]  i_src0_slot,
    input  logic [SLOT_IN_W-1:0]  i_src1_slot,
    input  logic                  i_invert0,
    input  logic                  i_invert1,
    input  logic [WORD_W-1:0]     i_ci_value,
    input  logic [CO_W-1:0]       i_co_number,
    input  logic [SLICE_IN_W-1:0] i_word_slice,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CO_W-1:0]       o_out_index,
    output logic [WORD_W-1:0]     o_out_value,
    output logic                  o_miter_fail,
    output logic [PAT_W-1:0]      o_fail_pattern
);

    localparam int SLOT_W  = $clog2(FRONT_SLOTS);
    localparam int SLICE_W = (WORD_SLICES > 1) ? $clog2(WORD_SLICES) : 1;
    localparam int ADDR_W  = SLOT_W + SLICE_W;
    localparam int QDATA_W = $bits(t_ctl) + 3 * ADDR_W + WORD_W + CO_W;

    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    logic [QDATA_W-1:0] q_din;
    logic [QDATA_W-1:0] q_dout;

    t_ctl              f_ctl;
    logic [ADDR_W-1:0] f_dest;
    logic [ADDR_W-1:0] f_src0;
    logic [ADDR_W-1:0] f_src1;
    logic [WORD_W-1:0] f_civ;
    logic [CO_W-1:0]   f_co;

    t_ctl              b_ctl;
    logic [ADDR_W-1:0] b_dest;
    logic [ADDR_W-1:0] b_src0;
    logic [ADDR_W-1:0] b_src1;
    logic [WORD_W-1:0] b_civ;
    logic [CO_W-1:0]   b_co;

    aigs_front #(
        .FRONT_SLOTS (FRONT_SLOTS),
        .WORD_SLICES (WORD_SLICES),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_dest_slot  (i_dest_slot),
        .i_src0_slot  (i_src0_slot),
        .i_src1_slot  (i_src1_slot),
        .i_invert0    (i_invert0),
        .i_invert1    (i_invert1),
        .i_ci_value   (i_ci_value),
        .i_co_number  (i_co_number),
        .i_word_slice (i_word_slice),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_ctl        (f_ctl),
        .o_dest_addr  (f_dest),
        .o_src0_addr  (f_src0),
        .o_src1_addr  (f_src1),
        .o_ci_value   (f_civ),
        .o_co_number  (f_co)
    );

    assign q_din = {f_ctl, f_dest, f_src0, f_src1, f_civ, f_co};

    aigs_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .i_pop   (pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    assign {b_ctl, b_dest, b_src0, b_src1, b_civ, b_co} = q_dout;

    aigs_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_pop          (pop),
        .i_ctl          (b_ctl),
        .i_dest_addr    (b_dest),
        .i_src0_addr    (b_src0),
        .i_src1_addr    (b_src1),
        .i_ci_value     (b_civ),
        .i_co_number    (b_co),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_index    (o_out_index),
        .o_out_value    (o_out_value),
        .o_miter_fail   (o_miter_fail),
        .o_fail_pattern (o_fail_pattern)
    );

endmodule
